>>> hw/rtl/sitoa_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes, the queue item type, the back-end state type
// and the table of decimal place multiples. No dependencies.
package sitoa_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int CMP_BITS    = VALUE_BITS + 4;
  localparam int CHAR_BITS   = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_BITS-1:0] DIGIT_BASE = CHAR_BITS'(48);
  localparam logic [CHAR_BITS-1:0] MINUS_CHAR = CHAR_BITS'(45);

  // Number of decimal places needed for the largest magnitude, 2**(VALUE_BITS-1).
  function automatic int max_digits_f();
    logic [CMP_BITS-1:0] lim;
    logic [CMP_BITS-1:0] r;
    int n;
    lim = '0;
    lim[VALUE_BITS-1] = 1'b1;
    r = CMP_BITS'(10);
    n = 1;
    for (int i = 0; i < 24; i++) begin
      if (r <= lim) begin
        r = r * CMP_BITS'(10);
        n++;
      end
    end
    return n;
  endfunction

  localparam int MAX_DIGITS = max_digits_f();
  localparam int POS_BITS   = $clog2(MAX_DIGITS);

  typedef logic [8:0][CMP_BITS-1:0]            mult_row_t;
  typedef logic [MAX_DIGITS-1:0][8:0][CMP_BITS-1:0] mult_tab_t;

  // Entry [p][k-1] holds k * 10**p for k = 1..9.
  function automatic mult_tab_t build_mult_tab();
    mult_tab_t t;
    logic [CMP_BITS-1:0] pw;
    pw = CMP_BITS'(1);
    for (int p = 0; p < MAX_DIGITS; p++) begin
      for (int k = 1; k <= 9; k++) begin
        t[p][k-1] = pw * CMP_BITS'(k);
      end
      pw = pw * CMP_BITS'(10);
    end
    return t;
  endfunction

  localparam mult_tab_t MULT_TAB = build_mult_tab();

  typedef struct packed {
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SIGN,
    BK_DIGIT
  } bk_state_t;

endpackage

>>> hw/rtl/sitoa_front.sv
// Front end: accepts an integer request and splits it into sign and magnitude.
// Depends on sitoa_pkg.
module sitoa_front (
  input  logic                             push,
  input  logic [sitoa_pkg::VALUE_BITS-1:0] in_value,
  input  logic                             q_full,
  output logic                             full,
  output logic                             q_push,
  output sitoa_pkg::job_t                  q_job
);
  import sitoa_pkg::*;

  logic neg;

  assign neg    = in_value[VALUE_BITS-1];
  assign full   = q_full;
  assign q_push = push && !q_full;

  // The most negative value negates to itself, which read unsigned is its magnitude.
  assign q_job.neg = neg;
  assign q_job.mag = neg ? (~in_value + VALUE_BITS'(1)) : in_value;

endmodule

>>> hw/rtl/sitoa_queue.sv
// Short queue of classified requests between the front and back ends.
// Depends on sitoa_pkg.
module sitoa_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  sitoa_pkg::job_t wr_job,
  input  logic            rd_en,
  output sitoa_pkg::job_t rd_job,
  output logic            q_empty,
  output logic            q_full
);
  import sitoa_pkg::*;

  job_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;
  logic                 do_wr, do_rd;

  assign q_empty = (count_r == QCNT_BITS'(0));
  assign q_full  = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_job  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_BITS'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_BITS'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + QCNT_BITS'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

>>> hw/rtl/sitoa_back.sv
// Back end: resolves one decimal place per cycle while the output is not held, most significant first,
// and holds each character in an output register. Depends on sitoa_pkg.
module sitoa_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  sitoa_pkg::job_t                 q_job,
  output logic                            q_pop,
  input  logic                            pop,
  output logic                            empty,
  output logic [sitoa_pkg::CHAR_BITS-1:0] out_character,
  output logic                            out_last
);
  import sitoa_pkg::*;

  bk_state_t             state_r, state_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [POS_BITS-1:0]   pos_r, pos_nxt;
  logic                  started_r, started_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_BITS-1:0]  out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  mult_row_t             mult;
  logic [CMP_BITS:0]     diff [9];
  logic [3:0]            digit;
  logic [VALUE_BITS-1:0] rem;
  logic                  adv;
  logic                  emit;
  logic                  load;
  logic                  out_wr;

  assign empty         = !out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;
  assign adv           = !out_valid_r || pop;

  // All nine multiples of the current place are tried at once; the multiples
  // rise with k, so the largest one that fits gives the digit.
  assign mult = MULT_TAB[pos_r];

  always_comb begin
    digit = 4'd0;
    rem   = mag_r;
    for (int k = 0; k < 9; k++) begin
      diff[k] = {1'b0, CMP_BITS'(mag_r)} - {1'b0, mult[k]};
      if (!diff[k][CMP_BITS]) begin
        digit = 4'(k + 1);
        rem   = diff[k][VALUE_BITS-1:0];
      end
    end
  end

  assign emit = started_r || (digit != 4'd0) || (pos_r == '0);

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    pos_nxt       = pos_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !pop;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_wr        = 1'b0;
    load          = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        load = !q_empty;
      end
      BK_SIGN: begin
        if (adv) begin
          out_wr       = 1'b1;
          out_char_nxt = MINUS_CHAR;
          out_last_nxt = 1'b0;
          state_nxt    = BK_DIGIT;
        end
      end
      BK_DIGIT: begin
        if (adv) begin
          out_wr       = emit;
          out_char_nxt = DIGIT_BASE + CHAR_BITS'(digit);
          out_last_nxt = (pos_r == '0);
          mag_nxt      = rem;
          started_nxt  = emit;
          if (pos_r == '0) begin
            load      = !q_empty;
            state_nxt = BK_IDLE;
          end else begin
            pos_nxt = pos_r - POS_BITS'(1);
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    if (load) begin
      mag_nxt     = q_job.mag;
      pos_nxt     = POS_BITS'(MAX_DIGITS - 1);
      started_nxt = 1'b0;
      state_nxt   = q_job.neg ? BK_SIGN : BK_DIGIT;
    end
    if (out_wr) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    pos_r      <= pos_nxt;
    started_r  <= started_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

>>> hw/rtl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text, one character per request on the output.
// Every decimal place is resolved in turn, one per cycle while the output is not held,
// suppressed leading zeros included; a negative value first emits its minus sign.
// The queue takes new values while an earlier one is still being converted.
// Reset (synchronous, active low) empties the queue and the output register.
// Depends on sitoa_pkg, sitoa_front, sitoa_queue and sitoa_back.
module signed_int_to_decimal_ascii (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic [sitoa_pkg::VALUE_BITS-1:0] in_value,
  output logic                             empty,
  input  logic                             pop,
  output logic [sitoa_pkg::CHAR_BITS-1:0]  out_character,
  output logic                             out_last
);
  import sitoa_pkg::*;

  job_t fr_job;
  job_t bk_job;
  logic fr_push;
  logic bk_pop;
  logic q_empty;
  logic q_full;

  sitoa_front u_front (
    .push     (push),
    .in_value (in_value),
    .q_full   (q_full),
    .full     (full),
    .q_push   (fr_push),
    .q_job    (fr_job)
  );

  sitoa_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fr_push),
    .wr_job  (fr_job),
    .rd_en   (bk_pop),
    .rd_job  (bk_job),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  sitoa_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_job         (bk_job),
    .q_pop         (bk_pop),
    .pop           (pop),
    .empty         (empty),
    .out_character (out_character),
    .out_last      (out_last)
  );

`ifndef SYNTH
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_character == MINUS_CHAR) ||
               ((out_character >= DIGIT_BASE) && (out_character <= DIGIT_BASE + CHAR_BITS'(9))))
    else $error("output character is neither a minus sign nor a digit");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_character == MINUS_CHAR)) |-> !out_last)
    else $error("minus sign flagged as the final character");

  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_empty && q_full) && !(bk_pop && q_empty))
    else $error("request queue flags inconsistent");
`endif

endmodule
